// ===== rtl/gn_pkg.sv =====
// shared constants and types for the gradient noise core
`default_nettype none

package gn_pkg;

   // input coordinate fraction width
   localparam int COORD_FRAC_BITS = 16;

   localparam logic [31:0] SeedReset = 32'd55;

   // hash constants, index 0 is the x component hash, index 1 the y component hash
   localparam logic [31:0] HashMulY   [2] = '{32'd71, 32'd89};
   localparam int          HashShift  [2] = '{13, 17};
   localparam logic [31:0] HashMulSq  [2] = '{32'd15731, 32'd24421};
   localparam logic [31:0] HashAddSq  [2] = '{32'd789221, 32'd544367};
   localparam logic [31:0] HashAddOut [2] = '{32'd1376312589, 32'd982451653};
   localparam logic [31:0] HashMask   = 32'h7fffffff;
   localparam logic signed [31:0] HashOne = 32'sh40000000;

   // substitute for an all-zero corner vector, q.30
   localparam logic signed [31:0] ZeroVecX = 32'sd751619277;
   localparam logic signed [31:0] ZeroVecY = 32'sd322122547;

   localparam int Corners   = 4;
   localparam int HashLat   = 5;
   localparam int SqrtSteps = 31;
   localparam int DivSteps  = 17;
   localparam int NormLat   = 2 + SqrtSteps + DivSteps + 1;
   localparam int BlendLat  = 7;

   typedef logic signed [31:0] comp_type;
   typedef logic signed [17:0] vec_type;
   typedef logic [15:0]        frac_type;
   typedef logic signed [17:0] noise_type;

endpackage

`default_nettype wire

// ===== rtl/gn_hash.sv =====
// seeded integer hashes giving one raw corner vector in q.30
`default_nettype none

module gn_hash (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [31:0]    seed,
   input  wire logic [31:0]    cell_x,
   input  wire logic [31:0]    cell_y,
   output gn_pkg::comp_type    comp [2]
);
   import gn_pkg::*;

   for (genvar g = 0; g < 2; g++) begin : g_hash
      logic [31:0] base;
      logic [31:0] p1_in;
      logic [31:0] p1_ff, p2_ff, p3_ff;
      logic [31:0] sq_ff, t_ff, u_ff;
      logic [31:0] sq_in, t_in, u_in, h_in;
      comp_type    comp_ff;

      always_comb begin
         base  = (cell_x + seed) + (cell_y + seed) * HashMulY[g];
         p1_in = base ^ (base << HashShift[g]);
         sq_in = p1_ff * p1_ff;
         t_in  = sq_ff * HashMulSq[g] + HashAddSq[g];
         u_in  = p3_ff * t_ff;
         h_in  = (u_ff + HashAddOut[g]) & HashMask;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p1_ff   <= p1_in;
            sq_ff   <= sq_in;
            p2_ff   <= p1_ff;
            t_ff    <= t_in;
            p3_ff   <= p2_ff;
            u_ff    <= u_in;
            comp_ff <= HashOne - $signed(h_in);
         end
      end

      assign comp[g] = comp_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/gn_norm.sv =====
// vector normalization: squares, bit-per-stage square root, bit-per-stage divide
`default_nettype none

module gn_norm (
   input  wire logic        clock,
   input  wire logic        en,
   input  gn_pkg::comp_type comp [2],
   output gn_pkg::vec_type  vec  [2]
);
   import gn_pkg::*;

   comp_type    a_sel, b_sel;
   logic [30:0] mag_in [2];
   logic        neg_in [2];

   // stage 1 squares, stage 2 sum
   logic [30:0] mag1_ff [2];
   logic        neg1_ff [2];
   logic [61:0] sq1_ff  [2];

   // sqrt stage arrays, index 0 is the sum stage
   logic [61:0] rem_ff  [0:SqrtSteps];
   logic [30:0] root_ff [0:SqrtSteps];
   logic [30:0] smag_ff [0:SqrtSteps][2];
   logic        sneg_ff [0:SqrtSteps][2];

   // divide stage arrays
   logic [47:0] drem_ff [1:DivSteps][2];
   logic [16:0] quo_ff  [1:DivSteps][2];
   logic        dneg_ff [1:DivSteps][2];
   logic [30:0] dsq_ff  [1:DivSteps];

   vec_type vec_ff [2];

   always_comb begin
      if (comp[0] == 32'sd0 && comp[1] == 32'sd0) begin
         a_sel = ZeroVecX;
         b_sel = ZeroVecY;
      end else begin
         a_sel = comp[0];
         b_sel = comp[1];
      end
      neg_in[0] = a_sel[31];
      neg_in[1] = b_sel[31];
      mag_in[0] = a_sel[31] ? 31'(-a_sel) : a_sel[30:0];
      mag_in[1] = b_sel[31] ? 31'(-b_sel) : b_sel[30:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 2; c++) begin
            mag1_ff[c]    <= mag_in[c];
            neg1_ff[c]    <= neg_in[c];
            sq1_ff[c]     <= mag_in[c] * mag_in[c];
            smag_ff[0][c] <= mag1_ff[c];
            sneg_ff[0][c] <= neg1_ff[c];
         end
         rem_ff[0]  <= sq1_ff[0] + sq1_ff[1];
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      localparam int Bit = SqrtSteps - 1 - k;
      logic [62:0] trial;
      logic        take;

      always_comb begin
         trial = ({32'd0, root_ff[k]} << (Bit + 1)) | (63'd1 << (2 * Bit));
         take  = {1'b0, rem_ff[k]} >= trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take ? 62'({1'b0, rem_ff[k]} - trial) : rem_ff[k];
            root_ff[k+1] <= take ? (root_ff[k] | (31'd1 << Bit)) : root_ff[k];
            smag_ff[k+1] <= smag_ff[k];
            sneg_ff[k+1] <= sneg_ff[k];
         end
      end
   end

   // divisor never zero: the substitute keeps the vector nonzero
   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      localparam int Bit = DivSteps - 1 - j;
      logic [30:0] dsor;
      logic [47:0] rem_src [2];
      logic [16:0] quo_src [2];
      logic        neg_src [2];
      logic [47:0] dshift;

      if (j == 0) begin : g_src
         always_comb begin
            dsor = root_ff[SqrtSteps];
            for (int c = 0; c < 2; c++) begin
               rem_src[c] = {1'b0, smag_ff[SqrtSteps][c], 16'd0};
               quo_src[c] = '0;
               neg_src[c] = sneg_ff[SqrtSteps][c];
            end
         end
      end else begin : g_src
         always_comb begin
            dsor = dsq_ff[j];
            for (int c = 0; c < 2; c++) begin
               rem_src[c] = drem_ff[j][c];
               quo_src[c] = quo_ff[j][c];
               neg_src[c] = dneg_ff[j][c];
            end
         end
      end

      assign dshift = {17'd0, dsor} << Bit;

      always_ff @(posedge clock) begin
         if (en) begin
            dsq_ff[j+1] <= dsor;
            for (int c = 0; c < 2; c++) begin
               if (rem_src[c] >= dshift) begin
                  drem_ff[j+1][c] <= rem_src[c] - dshift;
                  quo_ff[j+1][c]  <= quo_src[c] | (17'd1 << Bit);
               end else begin
                  drem_ff[j+1][c] <= rem_src[c];
                  quo_ff[j+1][c]  <= quo_src[c];
               end
               dneg_ff[j+1][c] <= neg_src[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 2; c++) begin
            vec_ff[c] <= dneg_ff[DivSteps][c] ? -$signed({1'b0, quo_ff[DivSteps][c]})
                                              :  $signed({1'b0, quo_ff[DivSteps][c]});
         end
      end
   end

   assign vec[0] = vec_ff[0];
   assign vec[1] = vec_ff[1];

endmodule

`default_nettype wire

// ===== rtl/gn_blend.sv =====
// dot products, x lerp, quintic fade, y lerp, round and saturate
`default_nettype none

module gn_blend (
   input  wire logic        clock,
   input  wire logic        en,
   input  gn_pkg::frac_type dx,
   input  gn_pkg::frac_type dy,
   input  gn_pkg::vec_type  vec_x [4],
   input  gn_pkg::vec_type  vec_y [4],
   output gn_pkg::noise_type noise
);
   import gn_pkg::*;

   // b0: products
   logic signed [17:0] ox [4];
   logic signed [17:0] oy [4];
   logic signed [35:0] px_w [4];
   logic signed [35:0] py_w [4];
   logic signed [34:0] prod_x_ff [4];
   logic signed [34:0] prod_y_ff [4];
   logic [31:0]        t2_w;
   logic signed [21:0] lin_w;
   logic signed [38:0] ip_w;
   logic [15:0]        t2_ff;
   logic signed [21:0] ip_ff;
   frac_type           dx0_ff, dy0_ff;

   // b1: dot sums, fade pieces
   logic signed [34:0] d_ff [4];
   logic [31:0]        t3_w;
   logic [15:0]        t3_ff;
   logic signed [21:0] inner_ff;
   frac_type           dx1_ff;

   // b2: differences, fade
   logic signed [38:0] f_w;
   logic signed [35:0] diff0_ff, diff1_ff;
   logic signed [34:0] d0_2_ff, d3_2_ff;
   logic signed [17:0] f2_ff;
   frac_type           dx2_ff;

   // b3: x lerps
   logic signed [52:0] l0_w, l1_w;
   logic signed [36:0] s0_w, s1_w;
   logic signed [34:0] px0_ff, px1_ff;
   logic signed [17:0] f3_ff;

   // b4, b5, b6
   logic signed [35:0] dp_ff;
   logic signed [34:0] px0_4_ff;
   logic signed [17:0] f4_ff;
   logic signed [53:0] r_w;
   logic signed [37:0] rs_w;
   logic signed [34:0] r_ff;
   logic signed [35:0] rr_w;
   logic signed [19:0] rq_w;
   noise_type          noise_ff;

   always_comb begin
      for (int c = 0; c < Corners; c++) begin
         ox[c] = $signed({2'b00, dx}) - ((c == 1 || c == 2) ? 18'sd65536 : 18'sd0);
         oy[c] = $signed({2'b00, dy}) - ((c == 2 || c == 3) ? 18'sd65536 : 18'sd0);
         px_w[c] = vec_x[c] * ox[c];
         py_w[c] = vec_y[c] * oy[c];
      end
      t2_w  = dy * dy;
      lin_w = $signed({6'b0, dy}) * 22'sd6 - 22'sd983040;
      ip_w  = lin_w * $signed({1'b0, dy});
      t3_w  = t2_ff * dy0_ff;
      f_w   = $signed({1'b0, t3_ff}) * inner_ff;
      l0_w  = $signed({1'b0, dx2_ff}) * diff0_ff;
      l1_w  = $signed({1'b0, dx2_ff}) * diff1_ff;
      s0_w  = {{2{d0_2_ff[34]}}, d0_2_ff} + l0_w[52:16];
      s1_w  = {{2{d3_2_ff[34]}}, d3_2_ff} + l1_w[52:16];
      r_w   = f4_ff * dp_ff;
      rs_w  = {{3{px0_4_ff[34]}}, px0_4_ff} + r_w[53:16];
      rr_w  = {r_ff[34], r_ff} + 36'sd32768;
      rq_w  = rr_w[35:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < Corners; c++) begin
            prod_x_ff[c] <= px_w[c][34:0];
            prod_y_ff[c] <= py_w[c][34:0];
            d_ff[c]      <= prod_x_ff[c] + prod_y_ff[c];
         end
         t2_ff    <= t2_w[31:16];
         ip_ff    <= ip_w[37:16];
         dx0_ff   <= dx;
         dy0_ff   <= dy;

         t3_ff    <= t3_w[31:16];
         inner_ff <= ip_ff + 22'sd655360;
         dx1_ff   <= dx0_ff;

         diff0_ff <= {d_ff[1][34], d_ff[1]} - {d_ff[0][34], d_ff[0]};
         diff1_ff <= {d_ff[2][34], d_ff[2]} - {d_ff[3][34], d_ff[3]};
         d0_2_ff  <= d_ff[0];
         d3_2_ff  <= d_ff[3];
         f2_ff    <= f_w[33:16];
         dx2_ff   <= dx1_ff;

         px0_ff   <= s0_w[34:0];
         px1_ff   <= s1_w[34:0];
         f3_ff    <= f2_ff;

         dp_ff    <= {px1_ff[34], px1_ff} - {px0_ff[34], px0_ff};
         px0_4_ff <= px0_ff;
         f4_ff    <= f3_ff;

         r_ff     <= rs_w[34:0];

         if (rq_w > 20'sd131071) begin
            noise_ff <= 18'sd131071;
         end else if (rq_w < -20'sd131072) begin
            noise_ff <= -18'sd131072;
         end else begin
            noise_ff <= rq_w[17:0];
         end
      end
   end

   assign noise = noise_ff;

endmodule

`default_nettype wire

// ===== rtl/gradient_noise_2d_core.sv =====
// top level of the 2d gradient noise core
//
//  channel  dir  fields (lsb first)                 handshake
//  req      in   x_coord[31:0], y_coord[63:32]      req_tvalid / req_tready
//  rsp      out  noise_out[17:0], zero pad [23:18]  rsp_tvalid / rsp_tready
//  csr      in   hash_seed[31:0]                    csr_wr_en, no wait
//
// one transaction per cycle sustained unless rsp stalls; each request passes the
// entry, hash, normalize (31-stage square root, 17-stage divide) and blend stages
// reset clears all valid bits and loads the seed with 55
// the whole pipeline advances together whenever the output register is empty or
// being drained, so a stall holds every stage and nothing is dropped or doubled
`default_nettype none

module gradient_noise_2d_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // x_coord [31:0], y_coord [63:32]
   output wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output wire logic [23:0] rsp_tdata,   // noise_out [17:0], zeros [23:18]
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   import gn_pkg::*;

   localparam int PipeDepth = 1 + HashLat + NormLat + BlendLat;
   localparam int FracDepth = 1 + HashLat + NormLat;
   localparam int FracShr   = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
   localparam int FracShl   = (COORD_FRAC_BITS >= 16) ? 0 : 16 - COORD_FRAC_BITS;
   localparam logic [31:0] FracMask = (32'd1 << COORD_FRAC_BITS) - 32'd1;

   logic        en;
   logic [31:0] seed_ff;

   // entry stage
   logic signed [31:0] x_in, y_in;
   logic [31:0]        cx_in, cy_in, xf_in, yf_in;
   logic [31:0]        cx_ff, cy_ff, cx1_ff, cy1_ff;
   logic [31:0]        corner_x [4];
   logic [31:0]        corner_y [4];

   // valid bits and fraction line riding beside the data
   logic     vld_ff [0:PipeDepth-1];
   frac_type dx_ff  [0:FracDepth-1];
   frac_type dy_ff  [0:FracDepth-1];

   comp_type  raw   [4][2];
   vec_type   vec   [4][2];
   vec_type   vec_x [4];
   vec_type   vec_y [4];
   noise_type noise;

   logic      rsp_valid_ff;
   noise_type rsp_noise_ff;

   // pipeline moves whenever the output slot is free or emptying
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // seed register
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SeedReset;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   // floor to the lattice cell and pull out the q.16 fraction
   always_comb begin
      x_in  = req_tdata[31:0];
      y_in  = req_tdata[63:32];
      cx_in = x_in >>> COORD_FRAC_BITS;
      cy_in = y_in >>> COORD_FRAC_BITS;
      xf_in = ((req_tdata[31:0] & FracMask) >> FracShr) << FracShl;
      yf_in = ((req_tdata[63:32] & FracMask) >> FracShr) << FracShl;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         cx1_ff   <= cx_in + 32'd1;
         cy1_ff   <= cy_in + 32'd1;
         dx_ff[0] <= xf_in[15:0];
         dy_ff[0] <= yf_in[15:0];
         for (int k = 1; k < FracDepth; k++) begin
            dx_ff[k] <= dx_ff[k-1];
            dy_ff[k] <= dy_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PipeDepth; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < PipeDepth; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // corners: 0 = (x, y), 1 = (x+1, y), 2 = (x+1, y+1), 3 = (x, y+1)
   always_comb begin
      corner_x[0] = cx_ff;  corner_y[0] = cy_ff;
      corner_x[1] = cx1_ff; corner_y[1] = cy_ff;
      corner_x[2] = cx1_ff; corner_y[2] = cy1_ff;
      corner_x[3] = cx_ff;  corner_y[3] = cy1_ff;
   end

   for (genvar c = 0; c < Corners; c++) begin : g_corner
      gn_hash u_hash (
         .clock  (clock),
         .en     (en),
         .seed   (seed_ff),
         .cell_x (corner_x[c]),
         .cell_y (corner_y[c]),
         .comp   (raw[c])
      );

      gn_norm u_norm (
         .clock (clock),
         .en    (en),
         .comp  (raw[c]),
         .vec   (vec[c])
      );

      assign vec_x[c] = vec[c][0];
      assign vec_y[c] = vec[c][1];
   end

   gn_blend u_blend (
      .clock (clock),
      .en    (en),
      .dx    (dx_ff[FracDepth-1]),
      .dy    (dy_ff[FracDepth-1]),
      .vec_x (vec_x),
      .vec_y (vec_y),
      .noise (noise)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[PipeDepth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_noise_ff <= noise;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_noise_ff};

endmodule

`default_nettype wire

// ===== rtl/gn_checker.sv =====
// port-level checks for the gradient noise core, bound to the top level
`default_nettype none

module gn_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // held result keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // pad bits above the noise value stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:18] == 6'd0)
      else $error("rsp_tdata pad bits set");

   // an empty output slot always lets requests in
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // a stalled result stalls the whole pipe
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while output stalled");

endmodule

bind gradient_noise_2d_core gn_checker u_gn_checker (.*);

`default_nettype wire

// ===== test/gradient_noise_2d_core_test.sv =====
// self-checking testbench for the 2d gradient noise core
`timescale 1ns / 100ps
`default_nettype none

// holds the noise values predicted for accepted points until they come back
class noise_scoreboard;
   logic [31:0]     seed;
   logic [17:0]     pending[$];
   int              mismatches;
   int              points_seen;
   int              values_seen;

   function new();
      seed = gn_pkg::SeedReset;
      mismatches = 0;
      points_seen = 0;
      values_seen = 0;
   endfunction

   function automatic longint shr_floor(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint hash_comp(int k, logic [31:0] cx, logic [31:0] cy);
      logic [31:0] p;
      p = (cx + seed) + (cy + seed) * gn_pkg::HashMulY[k];
      p = (p << gn_pkg::HashShift[k]) ^ p;
      p = (p * (p * p * gn_pkg::HashMulSq[k] + gn_pkg::HashAddSq[k])
           + gn_pkg::HashAddOut[k]) & gn_pkg::HashMask;
      return longint'(1073741824) - longint'({32'd0, p});
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint to_unit(longint c, longint s);
      longint unsigned m;
      longint q;
      m = (c < 0) ? -c : c;
      q = longint'((m << 16) / longint'(s));
      return (c < 0) ? -q : q;
   endfunction

   function automatic void gradient(logic [31:0] cx, logic [31:0] cy,
                                    output longint vx, output longint vy);
      longint a, b, s;
      a = hash_comp(0, cx, cy);
      b = hash_comp(1, cx, cy);
      // both components zero: fall back to the fixed (0.7, 0.3) vector
      if (a == 0 && b == 0) begin
         a = gn_pkg::ZeroVecX;
         b = gn_pkg::ZeroVecY;
      end
      s = int_sqrt(longint'(a * a) + longint'(b * b));
      if (s == 0) s = 1;
      vx = to_unit(a, s);
      vy = to_unit(b, s);
   endfunction

   function automatic longint mix(longint t, longint a, longint b);
      return a + shr_floor(t * (b - a), 16);
   endfunction

   function automatic longint quintic(longint t);
      longint t2, t3, inner;
      t2 = shr_floor(t * t, 16);
      t3 = shr_floor(t2 * t, 16);
      inner = shr_floor((6 * t - 15 * 65536) * t, 16) + 10 * 65536;
      return shr_floor(t3 * inner, 16);
   endfunction

   function automatic logic [17:0] noise_at(logic [31:0] x, logic [31:0] y);
      logic [31:0] cx, cy;
      longint dx, dy, v[8], d0, d1, d2, d3, r;
      cx = $signed(x) >>> 16;
      cy = $signed(y) >>> 16;
      dx = x[15:0];
      dy = y[15:0];
      gradient(cx, cy, v[0], v[1]);
      gradient(cx + 1, cy, v[2], v[3]);
      gradient(cx + 1, cy + 1, v[4], v[5]);
      gradient(cx, cy + 1, v[6], v[7]);
      d0 = v[0] * dx + v[1] * dy;
      d1 = v[2] * (dx - 65536) + v[3] * dy;
      d2 = v[4] * (dx - 65536) + v[5] * (dy - 65536);
      d3 = v[6] * dx + v[7] * (dy - 65536);
      r = mix(quintic(dy), mix(dx, d0, d1), mix(dx, d3, d2));
      r = shr_floor(r + 32768, 16);
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r[17:0];
   endfunction

   function void note_point(logic [63:0] data);
      pending.push_back(noise_at(data[31:0], data[63:32]));
      points_seen++;
   endfunction

   function void check_value(logic [23:0] data);
      logic [17:0] want;
      values_seen++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected noise value %h", data);
         return;
      end
      want = pending.pop_front();
      if (data[17:0] !== want || data[23:18] !== 6'd0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("noise mismatch: expected %h actual %h", want, data);
      end
   endfunction
endclass

module gradient_noise_2d_core_test;
   localparam int PipeLat = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   noise_scoreboard board = new();
   bit          long_hold = 1'b0;   // receiver held off while sender keeps offering

   always #1 clock = ~clock;

   gradient_noise_2d_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // offer one point after a random gap unless no_gap is set, hold until the transaction is taken
   // valid stays high after the transaction so back to back points need no gap
   task automatic send_point(logic [31:0] x, logic [31:0] y, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      do @(posedge clock); while (!req_tready);
      board.note_point({y, x});
   endtask

   // seed writes happen only with the pipeline drained
   task automatic write_seed(logic [31:0] s);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PipeLat + 4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.seed = s;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return {{16{1'b0}}, 16'($urandom())} - 32'h0000_8000 + ($urandom_range(0, 15) << 16);
         2: return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
         default: return $signed(32'($urandom_range(0, 2 * 65536 * 8))) - 32'sd524288;
      endcase
   endfunction

   // result side: random stalls, one long hold-off, stretches with none
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_value(rsp_tdata);
      end
   end

   initial begin
      logic [31:0] seeds[5];
      logic [31:0] edge_vals[8];
      int n;
      seeds = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1234_5678};
      edge_vals = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                    32'h0000_ffff, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, cell edges, lattice wrap, at reset seed
      for (int i = 0; i < 8; i++)
         send_point(edge_vals[i], edge_vals[(i * 3 + 1) % 8], 1'b0);
      for (int i = 0; i < 8; i++)
         send_point(edge_vals[(i + 2) % 8], edge_vals[i], 1'b0);

      // random phases over several seeds, extremes among them
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) write_seed(ph == 5 ? $urandom() : seeds[ph - 1]);
         n = 0;
         while (n < 290) begin
            if (ph == 2 && n == 100) long_hold = 1'b1;
            send_point(rand_coord(), rand_coord(), (ph == 2) || ($urandom_range(0, 4) == 0));
            n++;
         end
      end
      req_tvalid <= 1'b0;

      n = 0;
      while (board.pending.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (PipeLat + 8) @(posedge clock);
      $display("covered %0d points, %0d noise values checked, 6 seed settings",
               board.points_seen, board.values_seen);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("gradient_noise_2d_core regression: pass");
      else
         $display("gradient_noise_2d_core regression: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("gradient_noise_2d_core regression: fail");
      $finish;
   end
endmodule

`default_nettype wire
